[sv/aeps_pkg.sv]
// aeps_pkg: sizes, field widths and action codes of the active/expired scheduler
// used by the channel interfaces, the core and the testbench; aeps_ram does not use it
// depends on nothing
package aeps_pkg;

  // sizing of the queue structure
  localparam int LEVELS      = 4;
  localparam int QUEUE_DEPTH = 64;
  localparam int TASKS       = 1024;

  // field widths of a beat
  localparam int TASK_W      = $clog2(TASKS);
  localparam int ACT_W       = 2;
  localparam int PRIO_W      = 3;
  localparam int LEVEL_OUT_W = 2;

  // derived widths of the queue bookkeeping
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int FIFO_W    = 1 + LVL_W;
  localparam int FIFO_N    = 2 ** FIFO_W;
  localparam int ADDR_W    = FIFO_W + PTR_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  // request codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 2'd0,
    ACT_TAKE = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

endpackage

[sv/aeps_if.sv]
// aeps_in_if / aeps_out_if: valid/ready channels of the scheduler
// request channel and result channel, payload widths from aeps_pkg
interface aeps_in_if import aeps_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [TASK_W-1:0]        task_id;
  logic signed [PRIO_W-1:0] dyn_prio;
  logic [PRIO_W-1:0]        static_prio;

  modport source (output valid, action, task_id, dyn_prio, static_prio, input ready);
  modport sink   (input valid, action, task_id, dyn_prio, static_prio, output ready);
endinterface

interface aeps_out_if import aeps_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [TASK_W-1:0]      out_task;
  logic [LEVEL_OUT_W-1:0] out_level;
  logic                   overflow;

  modport source (output valid, found, out_task, out_level, overflow, input ready);
  modport sink   (input valid, found, out_task, out_level, overflow, output ready);
endinterface

[sv/active_expired_priority_scheduler_core.sv]
// active_expired_priority_scheduler_core: two banks of per-level task FIFOs
// depends on aeps_pkg, aeps_if (aeps_in_if, aeps_out_if) and aeps_ram
//
// usage
//   in_chan carries requests: add a task, take the next task, or peek at it.
//   an add with a non-negative dynamic priority goes to that level of the
//   active bank, a negative one goes to level static_prio-1 of the expired bank.
//   take/peek return the head of the highest non-empty active level; when the
//   active bank is empty the banks swap and the search is repeated.
//   out_chan carries exactly one result beat per request beat, in order.
// timing
//   a request beat is registered, then executed once the next stage is free
//   (bookkeeping update plus one read or write of the task RAM); the executed
//   request waits for the RAM read, then moves into the result register.
//   one request can be accepted per cycle while out_chan does not stall.
// reset and stall
//   rst_n clears all FIFO pointers and counts and makes bank 0 active; the task
//   RAM is not cleared, only written entries are ever read.
//   when out_chan stalls, the result register and one executed request hold,
//   one more request waits in the input register, then in_chan.ready drops.
module active_expired_priority_scheduler_core import aeps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  aeps_in_if.sink    in_chan,
  aeps_out_if.source out_chan
);

  // input register
  logic                     v1_r;
  action_t                  act1_r;
  logic [TASK_W-1:0]        task1_r;
  logic [PRIO_W-1:0]        dyn1_r;
  logic [PRIO_W-1:0]        stat1_r;

  // execute-to-result stage
  logic                     v2_r;
  logic                     s2_found_r;
  logic [TASK_W-1:0]        s2_task_r;
  logic [LEVEL_OUT_W-1:0]   s2_level_r;
  logic                     s2_ovf_r;
  logic                     s2_ram_r;

  // result register
  logic                     out_valid_r;
  logic                     o_found_r;
  logic [TASK_W-1:0]        o_task_r;
  logic [LEVEL_OUT_W-1:0]   o_level_r;
  logic                     o_ovf_r;

  // queue bookkeeping
  logic                     bank_r;
  logic [PTR_W-1:0]         head_r [FIFO_N];
  logic [PTR_W-1:0]         tail_r [FIFO_N];
  logic [CNT_W-1:0]         cnt_r  [FIFO_N];

  logic                     in_acc;
  logic                     exec;
  logic                     v2_adv;
  logic                     is_add;
  logic                     is_srch;
  logic [PRIO_W-1:0]        lvl_raw;
  logic [LVL_W-1:0]         add_lvl;
  logic                     add_bank;
  logic                     hit_a;
  logic                     hit_b;
  logic [LVL_W-1:0]         lvl_a;
  logic [LVL_W-1:0]         lvl_b;
  logic                     srch_hit;
  logic                     srch_bank;
  logic [LVL_W-1:0]         srch_lvl;
  logic [FIFO_W-1:0]        f_sel;
  logic [CNT_W-1:0]         cnt_sel;
  logic [PTR_W-1:0]         head_sel;
  logic [PTR_W-1:0]         tail_sel;
  logic                     full;
  logic                     do_push;
  logic                     do_pop;
  logic                     do_rd;
  logic [TASK_W-1:0]        ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (int'(p) >= QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  // handshake and pipeline advance
  assign v2_adv        = v2_r && (!out_valid_r || out_chan.ready);
  assign exec          = v1_r && (!v2_r || v2_adv);
  assign in_chan.ready = !v1_r || exec;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (exec) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act1_r  <= action_t'(in_chan.action);
      task1_r <= in_chan.task_id;
      dyn1_r  <= in_chan.dyn_prio;
      stat1_r <= in_chan.static_prio;
    end
  end

  // decode
  assign is_add  = (act1_r == ACT_ADD);
  assign is_srch = (act1_r == ACT_TAKE) || (act1_r == ACT_PEEK);

  // target level of an add, saturated into the level range
  always_comb begin
    if (dyn1_r[PRIO_W-1]) begin
      lvl_raw = (stat1_r == '0) ? '0 : stat1_r - PRIO_W'(1);
    end else begin
      lvl_raw = dyn1_r;
    end
    if (int'(lvl_raw) > LEVELS - 1) begin
      add_lvl = LVL_W'(LEVELS - 1);
    end else begin
      add_lvl = LVL_W'(lvl_raw);
    end
  end

  assign add_bank = dyn1_r[PRIO_W-1] ? ~bank_r : bank_r;

  // highest non-empty level in the active bank and in the expired bank
  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    lvl_a = '0;
    lvl_b = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_r[{bank_r, LVL_W'(l)}] != '0) begin
        hit_a = 1'b1;
        lvl_a = LVL_W'(l);
      end
      if (cnt_r[{~bank_r, LVL_W'(l)}] != '0) begin
        hit_b = 1'b1;
        lvl_b = LVL_W'(l);
      end
    end
  end

  // an empty active bank means the search runs on the swapped bank
  assign srch_hit  = hit_a || hit_b;
  assign srch_bank = hit_a ? bank_r : ~bank_r;
  assign srch_lvl  = hit_a ? lvl_a : lvl_b;

  // one FIFO is touched per request
  assign f_sel    = is_add ? {add_bank, add_lvl} : {srch_bank, srch_lvl};
  assign cnt_sel  = cnt_r[f_sel];
  assign head_sel = head_r[f_sel];
  assign tail_sel = tail_r[f_sel];
  assign full     = (cnt_sel == CNT_W'(QUEUE_DEPTH));

  assign do_push = exec && is_add && !full;
  assign do_pop  = exec && (act1_r == ACT_TAKE) && srch_hit;
  assign do_rd   = exec && is_srch && srch_hit;

  // task storage
  aeps_ram #(
    .WIDTH (TASK_W),
    .DEPTH (MEM_DEPTH)
  ) u_task_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr ({f_sel, tail_sel}),
    .wdata (task1_r),
    .re    (do_rd),
    .raddr ({f_sel, head_sel}),
    .rdata (ram_rdata)
  );

  // pointer, count and bank updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      for (int i = 0; i < FIFO_N; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (exec && is_srch && !hit_a) begin
        bank_r <= ~bank_r;
      end
      if (do_push) begin
        tail_r[f_sel] <= ptr_next(tail_sel);
        cnt_r[f_sel]  <= cnt_sel + CNT_W'(1);
      end
      if (do_pop) begin
        head_r[f_sel] <= ptr_next(head_sel);
        cnt_r[f_sel]  <= cnt_sel - CNT_W'(1);
      end
    end
  end

  // executed request waits here for the RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (exec) begin
      v2_r <= 1'b1;
    end else if (v2_adv) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      s2_found_r <= is_add ? !full : (is_srch && srch_hit);
      s2_task_r  <= is_add ? task1_r : '0;
      if (is_add) begin
        s2_level_r <= LEVEL_OUT_W'(add_lvl);
      end else if (is_srch && srch_hit) begin
        s2_level_r <= LEVEL_OUT_W'(srch_lvl);
      end else begin
        s2_level_r <= '0;
      end
      s2_ovf_r <= is_add && full;
      s2_ram_r <= is_srch && srch_hit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_adv) begin
      o_found_r <= s2_found_r;
      o_task_r  <= s2_ram_r ? ram_rdata : s2_task_r;
      o_level_r <= s2_level_r;
      o_ovf_r   <= s2_ovf_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.found     = o_found_r;
  assign out_chan.out_task  = o_task_r;
  assign out_chan.out_level = o_level_r;
  assign out_chan.overflow  = o_ovf_r;

  // an accepted add grows its FIFO by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> cnt_r[$past(f_sel)] == $past(cnt_sel) + CNT_W'(1))
    else $error("add did not grow its fifo count");

  // a take that returns a task shrinks its FIFO by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> cnt_r[$past(f_sel)] == $past(cnt_sel) - CNT_W'(1))
    else $error("take did not shrink its fifo count");

  // a search over an empty active bank swaps the banks
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && is_srch && !hit_a) |=> bank_r != $past(bank_r))
    else $error("empty active bank did not swap");

  // a stalled executed request keeps its read data
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !v2_adv) |=> (v2_r && $stable(ram_rdata)))
    else $error("read data lost while result stage stalled");

endmodule

[sv/aeps_ram.sv]
// aeps_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module aeps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[tb/sv/testbench.sv]
// testbench: request/result checks of active_expired_priority_scheduler_core
// depends on aeps_pkg, aeps_in_if, aeps_out_if and the core; a tracker class predicts result beats
// directed requests first, then random mixed, fill and drain runs with random gaps and stalls
module testbench import aeps_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FIFOS    = 2 * LEVELS;
  localparam int RANDOM_ITEMS = 1400;
  localparam int LIMIT_CYCLES = 640_000;

  typedef struct {
    action_t                  action;
    logic [TASK_W-1:0]        tid;
    logic signed [PRIO_W-1:0] dyn_prio;
    logic [PRIO_W-1:0]        static_prio;
  } sched_req_t;

  typedef struct {
    logic                   found;
    logic [TASK_W-1:0]      tid;
    logic [LEVEL_OUT_W-1:0] level;
    logic                   overflow;
  } sched_res_t;

  // tracks both banks of task fifos and holds the result beats still owed
  class task_queue_tracker;
    logic [TASK_W-1:0] slots [NUM_FIFOS][QUEUE_DEPTH];
    int unsigned       head  [NUM_FIFOS];
    int unsigned       tail  [NUM_FIFOS];
    int unsigned       count [NUM_FIFOS];
    bit                active;
    sched_res_t        owed_results [$];
    int unsigned       mismatches;

    function new();
      for (int f = 0; f < NUM_FIFOS; f++) begin
        head[f]  = 0;
        tail[f]  = 0;
        count[f] = 0;
      end
      active     = 1'b0;
      mismatches = 0;
    endfunction

    // highest non-empty level of the active bank, -1 if none
    function int top_level();
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
        if (count[int'(active) * LEVELS + lv] != 0) return lv;
      end
      return -1;
    endfunction

    function void note_request(sched_req_t r);
      sched_res_t exp_res;
      int         dyn;
      int         lv;
      int         f;
      bit         bank;
      exp_res = '{found: 1'b0, tid: '0, level: '0, overflow: 1'b0};
      dyn = int'(r.dyn_prio);
      case (r.action)
        ACT_ADD: begin
          // exhausted quantum goes to the expired bank at static_prio - 1
          if (dyn >= 0) begin
            lv   = dyn;
            bank = active;
          end else begin
            lv   = int'(r.static_prio) - 1;
            bank = ~active;
          end
          if (lv < 0) lv = 0;
          if (lv > LEVELS - 1) lv = LEVELS - 1;
          f = int'(bank) * LEVELS + lv;
          exp_res.tid   = r.tid;
          exp_res.level = LEVEL_OUT_W'(lv);
          if (count[f] >= QUEUE_DEPTH) begin
            exp_res.overflow = 1'b1;
          end else begin
            slots[f][tail[f]] = r.tid;
            tail[f]  = (tail[f] + 1 >= QUEUE_DEPTH) ? 0 : tail[f] + 1;
            count[f] = count[f] + 1;
            exp_res.found = 1'b1;
          end
        end
        ACT_TAKE, ACT_PEEK: begin
          // empty active bank swaps before the second search
          lv = top_level();
          if (lv < 0) begin
            active = ~active;
            lv     = top_level();
          end
          if (lv >= 0) begin
            f = int'(active) * LEVELS + lv;
            exp_res.found = 1'b1;
            exp_res.tid   = slots[f][head[f]];
            exp_res.level = LEVEL_OUT_W'(lv);
            if (r.action == ACT_TAKE) begin
              head[f]  = (head[f] + 1 >= QUEUE_DEPTH) ? 0 : head[f] + 1;
              count[f] = count[f] - 1;
            end
          end
        end
        default: ;
      endcase
      owed_results = {owed_results, exp_res};
    endfunction

    function void check_result(sched_res_t got);
      sched_res_t exp_res;
      if (owed_results.size() == 0) begin
        if (mismatches < 10)
          $display("result beat with nothing expected: found=%0b task=%0d level=%0d ovf=%0b",
                   got.found, got.tid, got.level, got.overflow);
        mismatches++;
        return;
      end
      exp_res = owed_results.pop_front();
      if (got.found !== exp_res.found || got.tid !== exp_res.tid ||
          got.level !== exp_res.level || got.overflow !== exp_res.overflow) begin
        if (mismatches < 10)
          $display({"result mismatch: exp found=%0b task=%0d level=%0d ovf=%0b, ",
                    "got found=%0b task=%0d level=%0d ovf=%0b"},
                   exp_res.found, exp_res.tid, exp_res.level, exp_res.overflow,
                   got.found, got.tid, got.level, got.overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  aeps_in_if  in_chan ();
  aeps_out_if out_chan ();

  active_expired_priority_scheduler_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  task_queue_tracker tracker = new();
  int unsigned       sent_items = 0;

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watch both channels and feed the tracker
  always @(posedge clk) begin
    sched_req_t req;
    sched_res_t res;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        req.action      = action_t'(in_chan.action);
        req.tid         = in_chan.task_id;
        req.dyn_prio    = in_chan.dyn_prio;
        req.static_prio = in_chan.static_prio;
        tracker.note_request(req);
      end
      if (out_chan.valid && out_chan.ready) begin
        res.found    = out_chan.found;
        res.tid      = out_chan.out_task;
        res.level    = out_chan.out_level;
        res.overflow = out_chan.overflow;
        tracker.check_result(res);
      end
    end
  end

  // result side back-pressure: short and long open stretches, short and a few long stalls
  initial begin
    int unsigned r;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (r < 55) begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(80, 200)) @(posedge clk);
      end else if (r < 92) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(10, 30)) @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    #(12ns * LIMIT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  function automatic sched_req_t make_req(action_t a, int tid, int dyn, int st);
    sched_req_t r;
    r.action      = a;
    r.tid         = TASK_W'(tid);
    r.dyn_prio    = PRIO_W'(dyn);
    r.static_prio = PRIO_W'(st);
    return r;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_static();
    if ($urandom_range(0, 99) < 85) return PRIO_W'($urandom_range(1, LEVELS));
    return PRIO_W'($urandom_range(0, 7));
  endfunction

  // one request beat, held until accepted; valid stays high for a zero gap
  task automatic send_request(sched_req_t r, int unsigned gap);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= r.action;
    in_chan.task_id     <= r.tid;
    in_chan.dyn_prio    <= r.dyn_prio;
    in_chan.static_prio <= r.static_prio;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (r.action != ACT_NONE) sent_items++;
  endtask

  // stimulus
  initial begin
    sched_req_t  req;
    sched_req_t  dir_reqs [$];
    int unsigned seg;
    int unsigned run_len;
    int unsigned r;
    int          fill_dyn;
    int          fill_st;
    bit          quiet;
    bit          drained = 1'b0;

    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.action      <= ACT_ADD;
    in_chan.task_id     <= '0;
    in_chan.dyn_prio    <= '0;
    in_chan.static_prio <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty take and peek with swaps, unused action, level extremes,
    // expired path with static priority in and out of range, drain past the swap
    dir_reqs = {dir_reqs, make_req(ACT_TAKE, 0, 0, 0)};
    dir_reqs = {dir_reqs, make_req(ACT_PEEK, 0, 0, 0)};
    dir_reqs = {dir_reqs, make_req(ACT_NONE, 1023, -1, 7)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 0, 0, 0)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 1023, 3, 7)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 341, 1, 2)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 682, 2, 5)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 100, -1, 1)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 101, -1, 4)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 102, -1, 0)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 103, -4, 7)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 104, -2, 5)};
    dir_reqs = {dir_reqs, make_req(ACT_ADD, 105, -3, 2)};
    dir_reqs = {dir_reqs, make_req(ACT_PEEK, 0, 0, 0)};
    repeat (5) dir_reqs = {dir_reqs, make_req(ACT_TAKE, 0, 0, 0)};
    dir_reqs = {dir_reqs, make_req(ACT_PEEK, 0, 0, 0)};
    repeat (6) dir_reqs = {dir_reqs, make_req(ACT_TAKE, 0, 0, 0)};
    foreach (dir_reqs[i]) send_request(dir_reqs[i], pick_gap(1'b0));

    // random runs: mixed traffic, fills of one fifo past full, drains past empty
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      seg   = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      if (seg < 6) begin
        run_len = $urandom_range(20, 60);
        repeat (run_len) begin
          r = $urandom_range(0, 99);
          if (r < 48) begin
            req = make_req(ACT_ADD, $urandom_range(0, 1023), $urandom_range(0, 7), 0);
            req.static_prio = pick_static();
          end else if (r < 84) begin
            req = make_req(ACT_TAKE, $urandom_range(0, 1023), $urandom_range(0, 7), 0);
            req.static_prio = PRIO_W'($urandom_range(0, 7));
          end else if (r < 97) begin
            req = make_req(ACT_PEEK, $urandom_range(0, 1023), $urandom_range(0, 7), 0);
            req.static_prio = PRIO_W'($urandom_range(0, 7));
          end else begin
            req = make_req(ACT_NONE, $urandom_range(0, 1023), $urandom_range(0, 7), 0);
            req.static_prio = PRIO_W'($urandom_range(0, 7));
          end
          send_request(req, pick_gap(quiet));
        end
      end else if (seg < 8) begin
        // same target every beat so the fifo fills and then refuses
        fill_dyn = $urandom_range(0, 1) ? $urandom_range(0, 3) : -int'($urandom_range(1, 4));
        fill_st  = pick_static();
        run_len  = $urandom_range(QUEUE_DEPTH + 2, QUEUE_DEPTH + 8);
        repeat (run_len) begin
          req = make_req(ACT_ADD, $urandom_range(0, 1023), fill_dyn, fill_st);
          send_request(req, pick_gap(quiet));
        end
      end else begin
        run_len = $urandom_range(30, 90);
        repeat (run_len) begin
          req = make_req(action_t'(($urandom_range(0, 99) < 85) ? ACT_TAKE : ACT_PEEK),
                         $urandom_range(0, 1023), $urandom_range(0, 7), 0);
          req.static_prio = PRIO_W'($urandom_range(0, 7));
          send_request(req, pick_gap(quiet));
        end
      end

      // hold off once until the block has returned everything
      if (!drained && sent_items > RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (tracker.owed_results.size() != 0) @(posedge clk);
      end
    end

    // let the last results come out
    in_chan.valid <= 1'b0;
    for (int i = 0; i < 2000 && tracker.owed_results.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
